@@ hdl/tjb_pkg.sv @@
// Package for the temporal Jacobian block: codes, command and control structs,
// the per-entry micro-step table and the floating-point constants.
// No dependencies.
package tjb_pkg;

  localparam int SCALAR_DEPTH        = 10;
  localparam int FRACTION_KINDS      = 3;
  localparam int MAX_FRACTIONS_DEF   = 3;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [63:0] DT_RESET     = 64'h3FF0_0000_0000_0000;
  localparam logic [1:0]  FCOUNT_RESET = 2'd2;
  localparam logic [63:0] FP_ZERO      = 64'h0000_0000_0000_0000;
  localparam logic [63:0] FP_NEG_ONE   = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] FP_DEF_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] FP_INF_MAG   = 63'h7FF0_0000_0000_0000;

  // configuration register indexes
  localparam logic REG_TIME_STEP      = 1'b0;
  localparam logic REG_FRACTION_COUNT = 1'b1;

  // operation codes and variable codes
  localparam logic       OP_LOAD     = 1'b0;
  localparam logic       OP_COMPUTE  = 1'b1;
  localparam logic [3:0] VC_FRAC_LO  = 4'd10;
  localparam logic [3:0] VC_FRAC_HI  = 4'd12;

  // scalar store addresses
  localparam logic [3:0] SA_VOL      = 4'd0;
  localparam logic [3:0] SA_DRDP     = 4'd1;
  localparam logic [3:0] SA_DRDT     = 4'd2;
  localparam logic [3:0] SA_RHO      = 4'd3;
  localparam logic [3:0] SA_HT       = 4'd7;
  localparam logic [3:0] SA_DHDP     = 4'd8;
  localparam logic [3:0] SA_DHDT     = 4'd9;

  typedef enum logic [1:0] {CMD_SCALAR, CMD_FRAC, CMD_COMPUTE} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  addr;
    logic [63:0] value;
  } cmd_t;

  typedef enum logic [1:0] {FOP_MUL, FOP_ADD, FOP_DIV} fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_W, SRC_VOL, SRC_DT, SRC_T, SRC_U, SRC_NEG_ONE
  } src_t;

  typedef enum logic [2:0] {EK_ZERO, EK_S1, EK_S2, EK_SUM, EK_E0, EK_DIAG} ekind_t;

  typedef struct packed {
    logic       frac;
    logic [3:0] addr;
  } ref_t;

  typedef struct packed {
    fop_t op;
    src_t a;
    src_t b;
    logic to_u;
    logic fin;
  } micro_t;

  typedef enum logic [3:0] {
    FS_IDLE, FS_MUL, FS_ALIGN, FS_ADD, FS_DNORM, FS_DIV, FS_NORM, FS_SUB, FS_ROUND, FS_DONE
  } fstate_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_SETUP, BS_OPA, BS_OPB, BS_GO, BS_WAIT, BS_EMIT
  } bstate_t;

  function automatic micro_t mk(fop_t op, src_t a, src_t b, logic to_u, logic fin);
    micro_t m;
    m.op = op; m.a = a; m.b = b; m.to_u = to_u; m.fin = fin;
    return m;
  endfunction

  // Entry steps: product or sum, times vol, over dt; accumulated in T (or U).
  function automatic micro_t micro_step(ekind_t k, logic [2:0] st);
    micro_t m;
    m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b1);
    case (k)
      EK_S1: begin
        if (st == 3'd0) m = mk(FOP_MUL, SRC_X, SRC_VOL, 1'b0, 1'b0);
      end
      EK_S2: begin
        case (st)
          3'd0:    m = mk(FOP_MUL, SRC_X, SRC_Y, 1'b0, 1'b0);
          3'd1:    m = mk(FOP_MUL, SRC_T, SRC_VOL, 1'b0, 1'b0);
          default: m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b1);
        endcase
      end
      EK_SUM: begin
        case (st)
          3'd0:    m = mk(FOP_MUL, SRC_X, SRC_Y, 1'b0, 1'b0);
          3'd1:    m = mk(FOP_MUL, SRC_Z, SRC_W, 1'b1, 1'b0);
          3'd2:    m = mk(FOP_ADD, SRC_T, SRC_U, 1'b0, 1'b0);
          3'd3:    m = mk(FOP_MUL, SRC_T, SRC_VOL, 1'b0, 1'b0);
          default: m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b1);
        endcase
      end
      EK_E0: begin
        case (st)
          3'd0:    m = mk(FOP_MUL, SRC_X, SRC_Y, 1'b0, 1'b0);
          3'd1:    m = mk(FOP_MUL, SRC_Z, SRC_W, 1'b1, 1'b0);
          3'd2:    m = mk(FOP_ADD, SRC_T, SRC_U, 1'b0, 1'b0);
          3'd3:    m = mk(FOP_ADD, SRC_T, SRC_NEG_ONE, 1'b0, 1'b0);
          3'd4:    m = mk(FOP_MUL, SRC_T, SRC_VOL, 1'b0, 1'b0);
          default: m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b1);
        endcase
      end
      EK_DIAG: begin
        case (st)
          3'd0:    m = mk(FOP_MUL, SRC_X, SRC_Y, 1'b0, 1'b0);
          3'd1:    m = mk(FOP_MUL, SRC_T, SRC_VOL, 1'b0, 1'b0);
          3'd2:    m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b0);
          3'd3:    m = mk(FOP_MUL, SRC_Z, SRC_VOL, 1'b1, 1'b0);
          3'd4:    m = mk(FOP_DIV, SRC_U, SRC_DT, 1'b1, 1'b0);
          default: m = mk(FOP_ADD, SRC_T, SRC_U, 1'b0, 1'b1);
        endcase
      end
      default: m = mk(FOP_DIV, SRC_T, SRC_DT, 1'b0, 1'b1);
    endcase
    return m;
  endfunction

endpackage

@@ hdl/tjb_front.sv @@
// Front end: takes input beats, decodes them into store writes or compute
// commands, drops loads that address nothing. Depends on tjb_pkg.
module tjb_front import tjb_pkg::*; #(
  parameter int MAX_FRACTIONS = MAX_FRACTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  variable_code,
  input  logic [1:0]  fraction_index,
  input  logic [63:0] cell_value,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic fv;
  cmd_t fcmd;
  cmd_t dec;
  logic keep;

  always_comb begin
    dec.value = cell_value;
    dec.addr  = variable_code;
    dec.kind  = CMD_SCALAR;
    keep      = 1'b1;
    if (operation == OP_COMPUTE) begin
      dec.kind = CMD_COMPUTE;
    end else if (variable_code < 4'(SCALAR_DEPTH)) begin
      dec.kind = CMD_SCALAR;
    end else if (variable_code <= VC_FRAC_HI && {30'd0, fraction_index} < MAX_FRACTIONS) begin
      dec.kind = CMD_FRAC;
      dec.addr = 4'((variable_code - VC_FRAC_LO) * MAX_FRACTIONS) + {2'b00, fraction_index};
    end else begin
      keep = 1'b0;
    end
  end

  assign in_ready  = !fv || cmd_ready;
  assign cmd_valid = fv;
  assign cmd       = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= keep;
    end else if (cmd_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fcmd <= dec;
    end
  end

endmodule

@@ hdl/tjb_queue.sv @@
// Short command queue between front end and sequencer.
// Depends on tjb_pkg.
module tjb_queue import tjb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/tjb_fpu.sv @@
// Shared iterative double-precision unit: multiply (four 27-bit partial
// products), add, divide (one quotient bit a cycle), round to nearest even.
// Depends on tjb_pkg.
module tjb_fpu import tjb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpu_req_t    req,
  output logic        done,
  output logic [63:0] result
);

  fstate_t state, state_next;

  logic [107:0]       acc;
  logic signed [13:0] e;
  logic               s;
  logic [52:0]        siga, sigb;
  logic signed [13:0] expa, expb;
  logic [6:0]         cnt;
  logic [53:0]        rem;
  logic [55:0]        q;
  logic [107:0]       bal;
  logic               eff_sub;
  logic               zsign;
  logic [63:0]        res;

  // operand decode
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan, sx;
  logic [10:0] ea_u, eb_u;
  logic [52:0] sa_sig, sb_sig;
  logic        spec;
  logic [63:0] spec_val;
  logic        x_is_a;

  always_comb begin
    a_zero = req.a[62:0] == '0;
    b_zero = req.b[62:0] == '0;
    a_inf  = req.a[62:0] == FP_INF_MAG;
    b_inf  = req.b[62:0] == FP_INF_MAG;
    a_nan  = req.a[62:52] == 11'h7FF && req.a[51:0] != '0;
    b_nan  = req.b[62:52] == 11'h7FF && req.b[51:0] != '0;
    sx     = req.a[63] ^ req.b[63];
    ea_u   = (req.a[62:52] == '0) ? 11'd1 : req.a[62:52];
    eb_u   = (req.b[62:52] == '0) ? 11'd1 : req.b[62:52];
    sa_sig = {req.a[62:52] != '0, req.a[51:0]};
    sb_sig = {req.b[62:52] != '0, req.b[51:0]};
    x_is_a = req.a[62:0] >= req.b[62:0];
    spec     = 1'b1;
    spec_val = FP_DEF_NAN;
    case (req.op)
      FOP_MUL: begin
        if (a_nan)                                spec_val = req.a | 64'h0008_0000_0000_0000;
        else if (b_nan)                           spec_val = req.b | 64'h0008_0000_0000_0000;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = FP_DEF_NAN;
        else if (a_inf || b_inf)                  spec_val = {sx, FP_INF_MAG};
        else                                      spec = 1'b0;
      end
      FOP_ADD: begin
        if (a_nan)                                spec_val = req.a | 64'h0008_0000_0000_0000;
        else if (b_nan)                           spec_val = req.b | 64'h0008_0000_0000_0000;
        else if (a_inf && b_inf && sx)            spec_val = FP_DEF_NAN;
        else if (a_inf)                           spec_val = req.a;
        else if (b_inf)                           spec_val = req.b;
        else                                      spec = 1'b0;
      end
      FOP_DIV: begin
        if (b_zero)                  spec_val = (a_nan || a_zero) ? FP_CANON_NAN
                                                                  : {sx, FP_INF_MAG};
        else if (a_nan)              spec_val = req.a | 64'h0008_0000_0000_0000;
        else if (b_nan)              spec_val = req.b | 64'h0008_0000_0000_0000;
        else if (a_inf && b_inf)     spec_val = FP_DEF_NAN;
        else if (a_inf)              spec_val = {sx, FP_INF_MAG};
        else if (b_inf || a_zero)    spec_val = {sx, 63'd0};
        else                         spec = 1'b0;
      end
      default: spec_val = FP_DEF_NAN;
    endcase
  end

  // multiply partial product
  logic [26:0]  pa, pb;
  logic [53:0]  pp;
  logic [6:0]   pp_sh;
  always_comb begin
    pa    = cnt[1] ? {1'b0, siga[52:27]} : siga[26:0];
    pb    = cnt[0] ? {1'b0, sigb[52:27]} : sigb[26:0];
    pp    = 54'(pa * pb);
    pp_sh = 7'd2 + ((cnt[0] ? 7'd27 : 7'd0) + (cnt[1] ? 7'd27 : 7'd0));
  end

  // alignment
  logic [107:0] yfull, bshift, blost;
  always_comb begin
    yfull  = {1'b0, sigb, 54'd0};
    bshift = yfull >> expb[6:0];
    blost  = yfull & ~({108{1'b1}} << expb[6:0]);
  end

  logic [107:0] afull, sum;
  assign afull = {1'b0, siga, 54'd0};
  assign sum   = eff_sub ? afull - bal : afull + bal;

  // division step
  logic        ge;
  logic [53:0] diff;
  assign ge   = rem >= {1'b0, sigb};
  assign diff = ge ? rem - {1'b0, sigb} : rem;

  // subnormal shift
  logic signed [13:0] sh_full;
  logic [6:0]         sh;
  logic [107:0]       acc_sh, acc_lost;
  always_comb begin
    sh_full  = 14'sd1 - e;
    sh       = (sh_full > 14'sd127) ? 7'd127 : sh_full[6:0];
    acc_sh   = acc >> sh;
    acc_lost = acc & ~({108{1'b1}} << sh);
  end

  // rounding
  logic [63:0] m;
  logic        inc;
  logic [13:0] e_m1;
  logic [65:0] pack;
  always_comb begin
    m    = acc[106:43];
    inc  = m[10] && ((|m[9:0]) || (|acc[42:0]) || m[11]);
    e_m1 = 14'(e - 14'sd1);
    pack = {e_m1, 52'd0} + 66'(m[63:11]) + 66'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      FS_IDLE: begin
        if (req.start) begin
          if (spec) state_next = FS_DONE;
          else begin
            case (req.op)
              FOP_MUL: state_next = FS_MUL;
              FOP_ADD: state_next = FS_ALIGN;
              default: state_next = FS_DNORM;
            endcase
          end
        end
      end
      FS_MUL:   if (cnt == 7'd3) state_next = FS_NORM;
      FS_ALIGN: state_next = FS_ADD;
      FS_ADD:   state_next = FS_NORM;
      FS_DNORM: if (siga[52] && sigb[52]) state_next = FS_DIV;
      FS_DIV:   if (cnt == 7'd55) state_next = FS_NORM;
      FS_NORM: begin
        if (acc[107]) state_next = FS_NORM;
        else if (acc == '0) state_next = FS_ROUND;
        else if (!acc[106] && e > 14'sd1) state_next = FS_NORM;
        else state_next = FS_SUB;
      end
      FS_SUB:   state_next = FS_ROUND;
      FS_ROUND: state_next = FS_DONE;
      FS_DONE: begin
        done       = 1'b1;
        state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  assign result = res;

  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        if (req.start) begin
          res <= spec_val;
          cnt <= '0;
          acc <= '0;
          case (req.op)
            FOP_MUL: begin
              siga <= sa_sig;
              sigb <= sb_sig;
              e    <= $signed({3'b000, ea_u}) + $signed({3'b000, eb_u}) - 14'sd1023;
              s    <= sx;
            end
            FOP_ADD: begin
              siga    <= x_is_a ? sa_sig : sb_sig;
              sigb    <= x_is_a ? sb_sig : sa_sig;
              e       <= $signed({3'b000, x_is_a ? ea_u : eb_u});
              expb    <= x_is_a ? $signed({3'b000, ea_u}) - $signed({3'b000, eb_u})
                                : $signed({3'b000, eb_u}) - $signed({3'b000, ea_u});
              s       <= x_is_a ? req.a[63] : req.b[63];
              eff_sub <= sx;
              zsign   <= req.a[63] & req.b[63];
            end
            default: begin
              siga <= sa_sig;
              sigb <= sb_sig;
              expa <= $signed({3'b000, ea_u});
              expb <= $signed({3'b000, eb_u});
              s    <= sx;
            end
          endcase
        end
      end
      FS_MUL: begin
        acc <= acc + (108'(pp) << pp_sh);
        cnt <= cnt + 7'd1;
      end
      FS_ALIGN: begin
        if (expb >= 14'sd108) bal <= {107'd0, sigb != '0};
        else                  bal <= bshift | {107'd0, blost != '0};
      end
      FS_ADD: begin
        acc <= sum;
        if (sum == '0) s <= zsign;
      end
      FS_DNORM: begin
        if (!siga[52]) begin
          siga <= {siga[51:0], 1'b0};
          expa <= expa - 14'sd1;
        end else if (!sigb[52]) begin
          sigb <= {sigb[51:0], 1'b0};
          expb <= expb - 14'sd1;
        end else begin
          rem <= {1'b0, siga};
          q   <= '0;
          cnt <= '0;
        end
      end
      FS_DIV: begin
        rem <= {diff[52:0], 1'b0};
        q   <= {q[54:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd55) begin
          acc <= {1'b0, q[54:0], ge, diff != '0, 50'd0};
          e   <= expa - expb + 14'sd1023;
        end
      end
      FS_NORM: begin
        if (acc[107]) begin
          acc <= {1'b0, acc[107:2], acc[1] | acc[0]};
          e   <= e + 14'sd1;
        end else if (acc != '0 && !acc[106] && e > 14'sd1) begin
          acc <= {acc[106:0], 1'b0};
          e   <= e - 14'sd1;
        end
      end
      FS_SUB: begin
        if (e < 14'sd1) begin
          acc <= acc_sh | {107'd0, acc_lost != '0};
          e   <= 14'sd1;
        end
      end
      FS_ROUND: begin
        if (acc == '0)                         res <= {s, 63'd0};
        else if (pack >= {3'b000, FP_INF_MAG}) res <= {s, FP_INF_MAG};
        else                                   res <= {s, pack[62:0]};
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/tjb_back.sv @@
// Back end: holds the cell stores, applies loads in order and walks the
// matrix entries, running each entry's micro-steps on the shared unit.
// Depends on tjb_pkg and tjb_fpu.
module tjb_back import tjb_pkg::*; #(
  parameter int MAX_FRACTIONS = MAX_FRACTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [63:0] time_step,
  input  logic [1:0]  fraction_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  row,
  output logic [2:0]  column,
  output logic [63:0] entry_value,
  output logic        last
);

  localparam int FDEPTH = FRACTION_KINDS * MAX_FRACTIONS;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int SAW    = $clog2(SCALAR_DEPTH);
  localparam logic [3:0] MAXW = 4'(MAX_FRACTIONS);

  logic [63:0] sstore [SCALAR_DEPTH];
  logic [63:0] fstore [FDEPTH];

  bstate_t     state, state_next;
  logic [2:0]  r, c, step;
  ekind_t      ek_r;
  logic [63:0] opa, opb, tr, ur, res;
  fpu_req_t    req;
  logic        fdone;
  logic [63:0] fres;

  tjb_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (fdone),
    .result (fres)
  );

  // matrix size
  logic [2:0] n_sat, last_idx;
  logic       at_last;
  assign n_sat    = ({1'b0, fraction_count} > 3'(MAX_FRACTIONS)) ? 3'(MAX_FRACTIONS)
                                                                 : {1'b0, fraction_count};
  assign last_idx = 3'd4 + n_sat;
  assign at_last  = (r == last_idx) && (c == last_idx);

  // entry decode
  ekind_t ek;
  ref_t   xr, yr, zr, wr, cd0, cd1, fy;
  logic   thermo;
  always_comb begin
    thermo = (c == 3'd0) || (c >= 3'd4);
    cd0 = '{frac: 1'b1, addr: 4'(c - 3'd5)};
    cd1 = '{frac: 1'b1, addr: MAXW + 4'(c - 3'd5)};
    if (c == 3'd0) begin
      cd0 = '{frac: 1'b0, addr: SA_DRDP};
      cd1 = '{frac: 1'b0, addr: SA_DHDP};
    end else if (c == 3'd4) begin
      cd0 = '{frac: 1'b0, addr: SA_DRDT};
      cd1 = '{frac: 1'b0, addr: SA_DHDT};
    end
    fy = '{frac: 1'b1, addr: (MAXW << 1) + 4'(r - 3'd5)};
    xr = cd0;
    yr = '{frac: 1'b0, addr: 4'd3 + {1'b0, r}};
    zr = '{frac: 1'b0, addr: SA_RHO};
    wr = cd1;
    ek = EK_ZERO;
    if (r == 3'd0) begin
      if (thermo) ek = EK_S1;
    end else if (r <= 3'd3) begin
      if (thermo) ek = EK_S2;
      else if (c == r) begin
        ek = EK_S1;
        xr = '{frac: 1'b0, addr: SA_RHO};
      end
    end else if (r == 3'd4) begin
      yr = '{frac: 1'b0, addr: SA_HT};
      if (c == 3'd0) begin
        ek = EK_E0;
        xr = '{frac: 1'b0, addr: SA_DRDP};
        wr = '{frac: 1'b0, addr: SA_DHDP};
      end else if (c <= 3'd3) begin
        ek = EK_S2;
        xr = '{frac: 1'b0, addr: SA_RHO};
        yr = '{frac: 1'b0, addr: 4'd3 + {1'b0, c}};
      end else begin
        ek = EK_SUM;
      end
    end else begin
      yr = fy;
      if (thermo) ek = (c == r) ? EK_DIAG : EK_S2;
    end
  end

  // operand fetch, one store read a cycle
  micro_t mic;
  src_t   cur;
  ref_t   rd;
  logic [63:0] sval, src_val;
  assign mic = micro_step(ek_r, step);
  assign cur = (state == BS_OPB) ? mic.b : mic.a;

  always_comb begin
    case (cur)
      SRC_X:   rd = xr;
      SRC_Y:   rd = yr;
      SRC_Z:   rd = zr;
      SRC_W:   rd = wr;
      default: rd = '{frac: 1'b0, addr: SA_VOL};
    endcase
    sval = rd.frac ? fstore[rd.addr[FAW-1:0]] : sstore[rd.addr[SAW-1:0]];
    case (cur)
      SRC_T:       src_val = tr;
      SRC_U:       src_val = ur;
      SRC_DT:      src_val = time_step;
      SRC_NEG_ONE: src_val = FP_NEG_ONE;
      default:     src_val = sval;
    endcase
  end

  assign req.start = state == BS_GO;
  assign req.op    = mic.op;
  assign req.a     = opa;
  assign req.b     = opb;

  logic emit_ok;
  assign emit_ok   = !out_valid || out_ready;
  assign cmd_ready = state == BS_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= BS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE:  if (cmd_valid && cmd.kind == CMD_COMPUTE) state_next = BS_SETUP;
      BS_SETUP: state_next = (ek == EK_ZERO) ? BS_EMIT : BS_OPA;
      BS_OPA:   state_next = BS_OPB;
      BS_OPB:   state_next = BS_GO;
      BS_GO:    state_next = BS_WAIT;
      BS_WAIT:  if (fdone) state_next = mic.fin ? BS_EMIT : BS_OPA;
      BS_EMIT:  if (emit_ok) state_next = at_last ? BS_IDLE : BS_SETUP;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_SCALAR:  sstore[cmd.addr[SAW-1:0]] <= cmd.value;
            CMD_FRAC:    fstore[cmd.addr[FAW-1:0]] <= cmd.value;
            CMD_COMPUTE: begin
              r <= '0;
              c <= '0;
            end
            default: ;
          endcase
        end
      end
      BS_SETUP: begin
        ek_r <= ek;
        step <= '0;
        res  <= FP_ZERO;
      end
      BS_OPA: opa <= src_val;
      BS_OPB: opb <= src_val;
      BS_WAIT: begin
        if (fdone) begin
          if (mic.to_u) ur <= fres;
          else          tr <= fres;
          if (mic.fin)  res <= fres;
          step <= step + 3'd1;
        end
      end
      BS_EMIT: begin
        if (emit_ok && !at_last) begin
          if (c == last_idx) begin
            c <= '0;
            r <= r + 3'd1;
          end else begin
            c <= c + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BS_EMIT && emit_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_EMIT && emit_ok) begin
      row         <= r;
      column      <= c;
      entry_value <= res;
      last        <= at_last;
    end
  end

endmodule

@@ hdl/temporal_jacobian_block.sv @@
// Temporal Jacobian block, top level: stream ports, configuration registers,
// front end, command queue and back end.
// Depends on tjb_pkg, tjb_front, tjb_queue, tjb_back.
//
// Usage: input beats on s_* either load one cell variable (s_tuser low) or
// request the Jacobian (s_tuser high). Each request produces (5+n)^2 beats on
// m_*, row-major, m_tlast on the final one; n is fraction_count, limited to
// MAX_FRACTIONS. Loads are taken one a cycle while the command queue has room.
// A load passes the front-end register and the command queue before it reaches
// the stores. Every nonzero entry runs 2 to 6 operations on one shared
// double-precision unit (multiply, add or divide), plus normalisation for
// subnormal operands, and each operation first has its two operands fetched.
// Each entry also passes set-up and output, which is all that structural
// zeros take. The divider's one-bit-a-cycle loop sets the rate of nonzero entries.
// Reset clears the queue and control state, sets time_step to 1.0 and
// fraction_count to 2; the stores hold nothing until written. A stalled
// m_tready holds the result register and the sequencer waits; loads keep
// filling the queue, then the front-end register, until both are full and s_tready falls.
module temporal_jacobian_block import tjb_pkg::*; #(
  parameter int MAX_FRACTIONS = MAX_FRACTIONS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // variable_code[3:0], fraction_index[5:4], cell_value[69:6]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // row[2:0], column[5:3], entry_value[69:6]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] time_step;
  logic [1:0]  fraction_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= DT_RESET;
      fraction_count <= FCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP:      time_step      <= cfg_data;
        REG_FRACTION_COUNT: fraction_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic cf_valid, cf_ready, cq_valid, cq_ready;
  cmd_t cf, cq;

  tjb_front #(.MAX_FRACTIONS(MAX_FRACTIONS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .operation      (s_tuser),
    .variable_code  (s_tdata[3:0]),
    .fraction_index (s_tdata[5:4]),
    .cell_value     (s_tdata[69:6]),
    .cmd_valid      (cf_valid),
    .cmd_ready      (cf_ready),
    .cmd            (cf)
  );

  tjb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cf_valid),
    .push_ready (cf_ready),
    .push_data  (cf),
    .pop_valid  (cq_valid),
    .pop_ready  (cq_ready),
    .pop_data   (cq)
  );

  logic [2:0]  row, column;
  logic [63:0] entry_value;

  tjb_back #(.MAX_FRACTIONS(MAX_FRACTIONS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cq_valid),
    .cmd_ready      (cq_ready),
    .cmd            (cq),
    .time_step      (time_step),
    .fraction_count (fraction_count),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .row            (row),
    .column         (column),
    .entry_value    (entry_value),
    .last           (m_tlast)
  );

  assign m_tdata = {2'b00, entry_value, column, row};

endmodule
